[rtl/core/swmm_pkg.sv]
// ----------------------------------------------------------------------------
// Sliding window min/max package
// Shared sizes, FSM state type and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package swmm_pkg;

  localparam int unsigned WINDOW_MAX  = 32;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned IDX_W       = $clog2(WINDOW_MAX);
  localparam int unsigned CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int unsigned TAG_W       = IDX_W + 1;
  localparam int unsigned WIN_W       = 6;
  localparam int unsigned ENT_W       = SAMPLE_BITS + TAG_W;

  localparam logic SEL_MAX = 1'b0;
  localparam logic SEL_MIN = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_HEAD,
    S_EXPIRE,
    S_RD_TAIL,
    S_DOMINATE,
    S_PUSH,
    S_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic sel;
    logic pop_head;
    logic pop_tail;
    logic push;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic expire;
    logic dominated;
  } sts_t;

endpackage

[rtl/core/swmm_ctrl.sv]
// ----------------------------------------------------------------------------
// Sliding window min/max controller
// Sequences expiry pops, dominance pops and the push for both deques.
// ----------------------------------------------------------------------------
module swmm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  swmm_pkg::sts_t sts_i,
  output swmm_pkg::cmd_t cmd_o
);

  swmm_pkg::state_e state_q, state_d;
  logic             sel_q, sel_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= swmm_pkg::S_IDLE;
      sel_q       <= swmm_pkg::SEL_MAX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    sel_d        = sel_q;
    cmd_o        = '0;
    cmd_o.sel    = sel_q;
    in_stall_o   = 1'b1;
    out_valid_d  = out_valid_q && out_stall_i;
    unique case (state_q)
      swmm_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          sel_d      = swmm_pkg::SEL_MAX;
          state_d    = swmm_pkg::S_RD_HEAD;
        end
      end
      swmm_pkg::S_RD_HEAD: state_d = swmm_pkg::S_EXPIRE;
      swmm_pkg::S_EXPIRE: begin
        if (sts_i.expire) begin
          cmd_o.pop_head = 1'b1;
          state_d        = swmm_pkg::S_RD_HEAD;
        end else begin
          state_d = swmm_pkg::S_DOMINATE;
        end
      end
      swmm_pkg::S_RD_TAIL: state_d = swmm_pkg::S_DOMINATE;
      swmm_pkg::S_DOMINATE: begin
        if (sts_i.dominated) begin
          cmd_o.pop_tail = 1'b1;
          state_d        = swmm_pkg::S_RD_TAIL;
        end else begin
          state_d = swmm_pkg::S_PUSH;
        end
      end
      swmm_pkg::S_PUSH: begin
        cmd_o.push = 1'b1;
        if (sel_q == swmm_pkg::SEL_MAX) begin
          sel_d   = swmm_pkg::SEL_MIN;
          state_d = swmm_pkg::S_RD_HEAD;
        end else begin
          state_d = swmm_pkg::S_OUT;
        end
      end
      swmm_pkg::S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = swmm_pkg::S_IDLE;
        end
      end
      default: state_d = swmm_pkg::S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/swmm_datapath.sv]
// ----------------------------------------------------------------------------
// Sliding window min/max datapath
// Deque storage, head/count pointers, sample tag counter and result registers.
// ----------------------------------------------------------------------------
module swmm_datapath (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      cfg_we_i,
  input  logic [swmm_pkg::WIN_W-1:0]                cfg_wdata_i,
  input  logic signed [swmm_pkg::SAMPLE_BITS-1:0]   sample_i,
  output logic signed [swmm_pkg::SAMPLE_BITS-1:0]   window_min_o,
  output logic signed [swmm_pkg::SAMPLE_BITS-1:0]   window_max_o,
  input  swmm_pkg::cmd_t                            cmd_i,
  output swmm_pkg::sts_t                            sts_o
);

  localparam int unsigned IW = swmm_pkg::IDX_W;
  localparam int unsigned CW = swmm_pkg::CNT_W;
  localparam int unsigned TW = swmm_pkg::TAG_W;
  localparam int unsigned SW = swmm_pkg::SAMPLE_BITS;

  logic [swmm_pkg::WIN_W-1:0] window_q;
  logic [TW-1:0]              ctr_q;
  logic [IW-1:0]              head_q [2];
  logic [CW-1:0]              cnt_q  [2];
  logic signed [SW-1:0]       sample_q;
  logic signed [SW-1:0]       res_min_q, res_max_q;
  logic signed [SW-1:0]       out_min_q, out_max_q;

  logic [swmm_pkg::ENT_W-1:0] mem_q [2*swmm_pkg::WINDOW_MAX];
  logic [swmm_pkg::ENT_W-1:0] rd_head_q, rd_tail_q;

  logic [IW-1:0]        head_cur, tail_idx, push_idx;
  logic [CW-1:0]        cnt_cur;
  logic [TW-1:0]        age;
  logic signed [SW-1:0] head_val, tail_val, extreme;

  assign head_cur = head_q[cmd_i.sel];
  assign cnt_cur  = cnt_q[cmd_i.sel];
  assign push_idx = head_cur + cnt_cur[IW-1:0];
  assign tail_idx = push_idx - IW'(1);
  assign head_val = $signed(rd_head_q[swmm_pkg::ENT_W-1 -: SW]);
  assign tail_val = $signed(rd_tail_q[swmm_pkg::ENT_W-1 -: SW]);
  assign age      = ctr_q - rd_head_q[TW-1:0];

  assign sts_o.expire    = (cnt_cur != '0) && (age >= window_q);
  assign sts_o.dominated = (cnt_cur != '0) &&
                           ((cmd_i.sel == swmm_pkg::SEL_MAX) ? (tail_val <= sample_q)
                                                             : (tail_val >= sample_q));
  assign extreme = (cnt_cur == '0) ? sample_q : head_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem_q[{cmd_i.sel, push_idx}] <= {sample_q, ctr_q};
    end
    rd_head_q <= mem_q[{cmd_i.sel, head_cur}];
    rd_tail_q <= mem_q[{cmd_i.sel, tail_idx}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= swmm_pkg::WIN_W'(swmm_pkg::WINDOW_MAX);
      ctr_q     <= '0;
      head_q[0] <= '0;
      head_q[1] <= '0;
      cnt_q[0]  <= '0;
      cnt_q[1]  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_wdata_i == '0) begin
          window_q <= swmm_pkg::WIN_W'(1);
        end else if (cfg_wdata_i > swmm_pkg::WIN_W'(swmm_pkg::WINDOW_MAX)) begin
          window_q <= swmm_pkg::WIN_W'(swmm_pkg::WINDOW_MAX);
        end else begin
          window_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.pop_head) begin
        head_q[cmd_i.sel] <= head_cur + IW'(1);
        cnt_q[cmd_i.sel]  <= cnt_cur - CW'(1);
      end else if (cmd_i.pop_tail) begin
        cnt_q[cmd_i.sel] <= cnt_cur - CW'(1);
      end else if (cmd_i.push) begin
        cnt_q[cmd_i.sel] <= cnt_cur + CW'(1);
      end
      if (cmd_i.finish) begin
        ctr_q <= ctr_q + TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= sample_i;
    end
    if (cmd_i.push) begin
      if (cmd_i.sel == swmm_pkg::SEL_MAX) begin
        res_max_q <= extreme;
      end else begin
        res_min_q <= extreme;
      end
    end
    if (cmd_i.finish) begin
      out_min_q <= res_min_q;
      out_max_q <= res_max_q;
    end
  end

  assign window_min_o = out_min_q;
  assign window_max_o = out_max_q;

endmodule

[rtl/core/sliding_window_min_max_core.sv]
// ----------------------------------------------------------------------------
// Sliding window min/max core
// Running minimum and maximum over the programmed window of signed samples.
// ----------------------------------------------------------------------------
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+---------------------------
//  in      | in_valid_i  | in_stall_o  | sample_i
//  out     | out_valid_o | out_stall_i | window_min_o, window_max_o
//  cfg     | cfg_we_i    | -           | cfg_wdata_i
//
// One transaction at a time: each accepted sample runs expiry pops, dominance
// pops and a push on the max deque, then on the min deque, before its result
// is registered; a new sample is accepted once the controller is back in idle.
// Each pop costs a re-read of the registered deque memory.
// The result register lets the next sample start while a result is stalled.
// Reset clears pointers, counts and tag counter; deque memory is not cleared.
// ----------------------------------------------------------------------------
module sliding_window_min_max_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [swmm_pkg::WIN_W-1:0]              cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [swmm_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [swmm_pkg::SAMPLE_BITS-1:0] window_min_o,
  output logic signed [swmm_pkg::SAMPLE_BITS-1:0] window_max_o
);

  swmm_pkg::cmd_t cmd;
  swmm_pkg::sts_t sts;

  swmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  swmm_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .sample_i     (sample_i),
    .window_min_o (window_min_o),
    .window_max_o (window_max_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

[rtl/core/swmm_checker.sv]
// ----------------------------------------------------------------------------
// Sliding window min/max checker
// Port-level assertions, bound to the core.
// ----------------------------------------------------------------------------
module swmm_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    in_valid_i,
  input logic                                    in_stall_o,
  input logic                                    out_valid_o,
  input logic                                    out_stall_i,
  input logic signed [swmm_pkg::SAMPLE_BITS-1:0] window_min_o,
  input logic signed [swmm_pkg::SAMPLE_BITS-1:0] window_max_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(window_min_o) &&
                                   $stable(window_max_o))
    else $error("stalled result changed");

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> window_min_o <= window_max_o)
    else $error("window min above window max");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second transaction accepted during processing");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a transaction in flight");

endmodule

bind sliding_window_min_max_core swmm_checker u_swmm_checker (.*);

[test/sliding_window_min_max_core_test.sv]
// ----------------------------------------------------------------------------
// Sliding window min/max core regression
// Streams signed samples through the core and predicts the running window
// minimum and maximum with a pair of monotonic deques held as SV queues.
// Window width is reprogrammed between phases, clamped values included.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sliding_window_min_max_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned ITEM_TARGET = 1300;

  typedef logic signed [swmm_pkg::SAMPLE_BITS-1:0] sample_t;
  typedef logic [swmm_pkg::WIN_W-1:0] win_t;

  typedef enum int {PAT_NOISE, PAT_NARROW, PAT_RISE, PAT_FALL, PAT_EXTREME} pattern_e;

  class extremes_scoreboard;
    typedef struct {
      sample_t                    value;
      logic [swmm_pkg::TAG_W-1:0] tag;
    } slot_t;
    typedef struct {
      sample_t lo;
      sample_t hi;
    } extremes_t;

    slot_t                      max_deque[$];
    slot_t                      min_deque[$];
    extremes_t                  expected_extremes[$];
    logic [swmm_pkg::TAG_W-1:0] tag_next;
    int unsigned                width;
    int unsigned                failures;

    function new();
      tag_next = '0;
      width    = swmm_pkg::WINDOW_MAX;
      failures = 0;
    endfunction

    function void set_window(win_t v);
      if (v == 0) width = 1;
      else if (v > swmm_pkg::WINDOW_MAX) width = swmm_pkg::WINDOW_MAX;
      else width = v;
    endfunction

    function sample_t slide(ref slot_t dq[$], input sample_t s, input bit keep_max);
      logic [swmm_pkg::TAG_W-1:0] age;
      slot_t                      fresh;
      while (dq.size() > 0) begin
        age = tag_next - dq[0].tag;
        if (age < width) break;
        void'(dq.pop_front());
      end
      while (dq.size() > 0) begin
        if (keep_max ? (dq[$].value > s) : (dq[$].value < s)) break;
        void'(dq.pop_back());
      end
      if (dq.size() >= swmm_pkg::WINDOW_MAX) void'(dq.pop_front());
      fresh.value = s;
      fresh.tag   = tag_next;
      dq.push_back(fresh);
      return dq[0].value;
    endfunction

    function void take_sample(sample_t s);
      extremes_t e;
      e.hi = slide(max_deque, s, 1'b1);
      e.lo = slide(min_deque, s, 1'b0);
      tag_next = tag_next + 1'b1;
      expected_extremes.push_back(e);
    endfunction

    function void compare_result(sample_t lo, sample_t hi);
      extremes_t e;
      if (expected_extremes.size() == 0) begin
        $error("unexpected result: window_min %0d window_max %0d", lo, hi);
        failures++;
        return;
      end
      e = expected_extremes.pop_front();
      if (lo !== e.lo) begin
        $error("window_min: expected %0d, got %0d", e.lo, lo);
        failures++;
      end
      if (hi !== e.hi) begin
        $error("window_max: expected %0d, got %0d", e.hi, hi);
        failures++;
      end
    endfunction

    function int unsigned pending();
      return expected_extremes.size();
    endfunction
  endclass

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    cfg_we_i;
  win_t    cfg_wdata_i;
  logic    in_valid_i;
  logic    in_stall_o;
  sample_t sample_i;
  logic    out_valid_o;
  logic    out_stall_i;
  sample_t window_min_o;
  sample_t window_max_o;

  extremes_scoreboard tracker = new();
  bit                 quiet;
  sample_t            ramp;
  int unsigned        cycles;

  sliding_window_min_max_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .window_min_o(window_min_o),
    .window_max_o(window_max_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("sliding_window_min_max_core regression: fail");
      $finish;
    end
  end

  task automatic write_window(win_t v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    tracker.set_window(v);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_sample(sample_t s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    do @(posedge clk_i); while (in_stall_o);
    tracker.take_sample(s);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  function automatic sample_t draw_sample(pattern_e pat);
    case (pat)
      PAT_NARROW: return sample_t'($signed($urandom_range(0, 6)) - 3);
      PAT_RISE: begin
        ramp = ramp + sample_t'($urandom_range(0, 400));
        return ramp;
      end
      PAT_FALL: begin
        ramp = ramp - sample_t'($urandom_range(0, 400));
        return ramp;
      end
      PAT_EXTREME: begin
        case ($urandom_range(0, 3))
          0:       return sample_t'(16'h8000);
          1:       return sample_t'(16'h7fff);
          2:       return sample_t'(-1);
          default: return sample_t'(0);
        endcase
      end
      default: return sample_t'($urandom);
    endcase
  endfunction

  // result side: check and hold off at random
  initial begin : result_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        tracker.compare_result(window_min_o, window_max_o);
        hold = quiet ? 0 : $urandom_range(0, 9);
        if (hold > 0) out_stall_i <= 1'b1;
      end else if (out_stall_i) begin
        hold--;
        if (hold <= 0) out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    shortint     opening[10] = '{0, 32767, -32768, -1, 1, 5, 5, 5, 4, 6};
    win_t        fixed_widths[8] = '{6'd0, 6'd63, 6'd1, 6'd32, 6'd2, 6'd33, 6'd31, 6'd17};
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    pattern_e    pat;

    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= '0;
    in_valid_i  <= 1'b0;
    sample_i    <= '0;
    out_stall_i <= 1'b0;
    cycles      <= 0;
    quiet       = 1'b0;
    ramp        = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset width, extremes, ties on both deques
    foreach (opening[i]) send_sample(sample_t'(opening[i]));
    drain();
    // shrink mid-stream: older entries expire at once
    write_window(6'd3);
    send_sample(sample_t'(7));
    send_sample(sample_t'(-2));
    send_sample(sample_t'(8));
    drain();
    // zero stored as one
    write_window(6'd0);
    send_sample(sample_t'(-5));
    send_sample(sample_t'(9));
    drain();
    // oversized stored as max, window refills over time
    write_window(6'd63);
    send_sample(sample_t'(2));
    send_sample(sample_t'(3));
    send_sample(sample_t'(-32768));
    drain();
    sent = 18;

    phase = 0;
    while (sent < ITEM_TARGET) begin
      if (phase < 8) write_window(fixed_widths[phase]);
      else write_window(win_t'($urandom_range(0, 63)));
      quiet = ($urandom_range(0, 3) == 0);
      pat   = pattern_e'($urandom_range(0, 4));
      n     = $urandom_range(20, 80);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) pat = pattern_e'($urandom_range(0, 4));
        send_sample(draw_sample(pat));
      end
      sent += n;
      drain();
      phase++;
    end

    quiet = 1'b0;
    repeat (200) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0)
      $display("sliding_window_min_max_core regression: pass");
    else
      $display("sliding_window_min_max_core regression: fail");
    $finish;
  end

endmodule
